[rtl/nfmv_pkg.sv]
// types and constants shared by the chat message field validator
package nfmv_pkg;

  // message kinds
  localparam logic [1:0] KIND_AUTH = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_JOIN = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  // field index reported for header bytes and bytes after the message
  localparam logic [1:0] FIELD_NONE = 2'd3;

  // field counters
  localparam logic [1:0] FIELD_0 = 2'd0;
  localparam logic [1:0] FIELD_1 = 2'd1;
  localparam logic [1:0] NFIELDS_AUTH  = 2'd3;
  localparam logic [1:0] NFIELDS_OTHER = 2'd2;

  // field length counter width and saturation point
  localparam int unsigned LEN_W = 11;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // character classes
  typedef enum logic [1:0] {
    CLS_ALNUM = 2'd0,
    CLS_PRINT = 2'd1,
    CLS_SPACE = 2'd2
  } cls_e;

  typedef struct packed {
    logic [1:0] kind;
    logic       first;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] field_index;
    logic       is_text;
    logic       done_res;
    logic       accepted;
  } out_t;

  typedef struct packed {
    logic [2:0]       header_left;
    logic [1:0]       kind_latch;
    logic [1:0]       field_number;
    logic [LEN_W-1:0] field_length;
    logic             still_valid;
    logic             finished;
  } state_t;

  localparam state_t STATE_RESET = '{
    header_left:  3'd0,
    kind_latch:   KIND_AUTH,
    field_number: FIELD_0,
    field_length: '0,
    still_valid:  1'b1,
    finished:     1'b0
  };

  function automatic logic class_ok(cls_e cls, logic [7:0] b);
    logic ok;
    begin
      case (cls)
        CLS_ALNUM: begin
          ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || (b == 8'h2D);
        end
        CLS_PRINT: ok = (b >= 8'h21 && b <= 8'h7E);
        CLS_SPACE: ok = (b >= 8'h20 && b <= 8'h7E);
        default:   ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

endpackage

[rtl/nfmv_step.sv]
// per-byte parse step: next message state and the result for one byte
module nfmv_step import nfmv_pkg::*; #(
  parameter int unsigned HEADER_LEN      = 3,
  parameter int unsigned NAME_MAX_LEN    = 20,
  parameter int unsigned SECRET_MAX_LEN  = 128,
  parameter int unsigned CONTENT_MAX_LEN = 1400
) (
  input  state_t state_i,
  input  in_t    data_i,
  output state_t state_o,
  output out_t   result_o
);

  localparam logic [LEN_W-1:0] NameLim    = LEN_W'(NAME_MAX_LEN);
  localparam logic [LEN_W-1:0] SecretLim  = LEN_W'(SECRET_MAX_LEN);
  localparam logic [LEN_W-1:0] ContentLim = LEN_W'(CONTENT_MAX_LEN);

  state_t           s;
  logic [1:0]       nfields;
  logic [1:0]       fn_inc;
  logic [LEN_W-1:0] limit;
  cls_e             cls;

  // restart on the first byte of a message
  always_comb begin
    s = state_i;
    if (data_i.first) begin
      s.kind_latch   = data_i.kind;
      s.header_left  = 3'(HEADER_LEN);
      s.field_number = FIELD_0;
      s.field_length = '0;
      s.still_valid  = (data_i.kind != KIND_BAD);
      s.finished     = 1'b0;
    end
  end

  // limit and class of the current field
  always_comb begin
    limit = NameLim;
    cls   = CLS_PRINT;
    case (s.kind_latch)
      KIND_AUTH: begin
        if (s.field_number == FIELD_0) begin
          cls = CLS_ALNUM;
        end else if (s.field_number == FIELD_1) begin
          cls = CLS_PRINT;
        end else begin
          limit = SecretLim;
          cls   = CLS_ALNUM;
        end
      end
      KIND_JOIN: begin
        cls = (s.field_number == FIELD_0) ? CLS_ALNUM : CLS_PRINT;
      end
      default: begin
        if (s.field_number != FIELD_0) begin
          limit = ContentLim;
          cls   = CLS_SPACE;
        end
      end
    endcase
  end

  assign nfields = (s.kind_latch == KIND_AUTH) ? NFIELDS_AUTH : NFIELDS_OTHER;
  assign fn_inc  = s.field_number + 2'd1;

  always_comb begin
    state_o              = s;
    result_o.field_index = FIELD_NONE;
    result_o.is_text     = 1'b0;
    result_o.done_res    = 1'b0;
    if (s.finished) begin
      // bytes after the last terminator are ignored
    end else if (s.header_left != 3'd0) begin
      state_o.header_left = s.header_left - 3'd1;
    end else begin
      result_o.field_index = s.field_number;
      if (data_i.data_byte == 8'h00) begin
        if (s.field_length == '0) begin
          state_o.still_valid = 1'b0;
        end
        state_o.field_length = '0;
        state_o.field_number = fn_inc;
        if (fn_inc >= nfields) begin
          state_o.finished  = 1'b1;
          result_o.done_res = 1'b1;
        end
      end else begin
        result_o.is_text = 1'b1;
        if (s.field_length >= limit || !class_ok(cls, data_i.data_byte)) begin
          state_o.still_valid = 1'b0;
        end
        if (s.field_length != LEN_SAT) begin
          state_o.field_length = s.field_length + LEN_W'(1);
        end
      end
    end
    result_o.accepted = state_o.still_valid;
  end

endmodule

[rtl/nul_field_message_validator_unit.sv]
// top level of the chat message field validator
// One byte of a chat message is taken per transfer on the input channel and
// one result per byte leaves on the output channel, in order. While the
// output is not stalled the block sustains one byte per clock cycle: a
// byte sits in the input register while the parse step (header skip, field
// split on NUL, length and character class checks) updates the message
// state, and its result is then held in the output register, from which it
// is offered. While the output is stalled the input register still takes
// one more byte, and further bytes are stalled until the result moves on.
// The first byte of a message (first set) latches the kind and restarts the
// parse; accepted on the final terminator gives the verdict.
module nul_field_message_validator_unit import nfmv_pkg::*; #(
  parameter int unsigned HEADER_LEN      = 3,
  parameter int unsigned NAME_MAX_LEN    = 20,
  parameter int unsigned SECRET_MAX_LEN  = 128,
  parameter int unsigned CONTENT_MAX_LEN = 1400
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // input register
  logic   in_valid_q;
  in_t    in_q;
  // message state and output register
  state_t state_q, state_d;
  out_t   result_d;
  logic   out_valid_q;
  out_t   out_q;

  logic advance;
  logic in_take;

  // the byte in the input register moves on when the output slot is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  nfmv_step #(
    .HEADER_LEN     (HEADER_LEN),
    .NAME_MAX_LEN   (NAME_MAX_LEN),
    .SECRET_MAX_LEN (SECRET_MAX_LEN),
    .CONTENT_MAX_LEN(CONTENT_MAX_LEN)
  ) u_step (
    .state_i (state_q),
    .data_i  (in_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  // input side valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // message state only changes when a byte is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output valid flag: set by a processed byte, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/nfmv_checker.sv]
// port-level checks for the chat message field validator
module nfmv_checker import nfmv_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // terminator of the last field is never content and lies in a real field
  a_done_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      !out_data_o.is_text &&
      (out_data_o.field_index == FIELD_1 || out_data_o.field_index == 2'd2))
    else $error("done on a non-terminator");

  // content bytes always belong to a field
  a_text_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_text |-> out_data_o.field_index != FIELD_NONE)
    else $error("content byte outside a field");

  // the input is only held off while a result waits on a stalled output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

endmodule

bind nul_field_message_validator_unit nfmv_checker u_nfmv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
